>>> rtl/i2a_pkg.sv
// Shared constants, radix codes and digit helpers for the integer to ASCII converter.
package i2a_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_BITS        = 32;

  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_BIN = 2'd1;
  localparam logic [1:0] CMD_HEX = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_X    = 8'h78;

  // decimal digits needed for 2^(vb-1); 0.3 per bit is just below log10(2), close enough
  function automatic int dec_digits(input int vb);
    return (vb * 3) / 10 + 1;
  endfunction

  function automatic int hex_digits(input int vb);
    return (vb + 3) / 4;
  endfunction

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) return CHAR_ZERO + d8;
    else           return CHAR_A + d8 - 8'd10;
  endfunction

endpackage

>>> rtl/i2a_dabble.sv
// Iterative binary to BCD unit: one shift and add-3 step per cycle.
module i2a_dabble
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [VALUE_BITS-1:0]                   bin,
  output logic                                    done,
  output logic [4*dec_digits(VALUE_BITS)-1:0]     bcd
);

  localparam int D  = dec_digits(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] sh;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [4*D-1:0]        adj;

  // digits >= 5 get +3 before the shift
  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < D; i++) begin
      dig = bcd[4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      sh   <= bin;
      bcd  <= '0;
      cnt  <= CW'(VALUE_BITS);
    end else if (busy) begin
      bcd <= {adj[4*D-2:0], sh[VALUE_BITS-1]};
      sh  <= sh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) done <= 1'b0;
  end

endmodule

>>> rtl/integer_to_ascii_digits_core.sv
// Top level: radix conversion sequencer, digit emitter and output register.
// First character: decimal waits for the bit-per-cycle BCD shift unit, then drops leading
// zeros one per cycle; binary drops leading zeros likewise; hex first sends the 0x prefix.
// The next item is accepted once the last character of the current one is loaded into the
// output register; decimal items also wait for the BCD shift unit before any output. One item in
// flight. Synchronous active-high reset empties the sequencer and the output register.
module integer_to_ascii_digits_core
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          cmd,
  input  logic signed [IN_BITS-1:0] value,
  output logic                char_valid,
  input  logic                char_ready,
  output logic [7:0]          character,
  output logic                last
);

  localparam int D   = dec_digits(VALUE_BITS);
  localparam int H   = hex_digits(VALUE_BITS);
  localparam int W0  = (4*D > VALUE_BITS) ? 4*D : VALUE_BITS;
  localparam int W   = (W0 > 4*H) ? W0 : 4*H;      // digit window width
  localparam int CW  = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DABBLE, S_PFX0, S_PFX1, S_SKIP, S_EMIT
  } state_t;

  state_t        state;
  logic [W-1:0]  work;       // digits left-aligned, most significant at the top
  logic [CW-1:0] rem;        // digits still in the window
  logic          mode_bin;   // 1-bit digits instead of nibbles

  logic [63:0]            wide;
  logic [VALUE_BITS-1:0]  raw;
  logic [VALUE_BITS-1:0]  mag;
  logic [3:0]             top;
  logic                   out_free;
  logic                   accept;
  logic                   dd_done;
  logic [4*D-1:0]         bcd;

  // sign-extend the port to 64 bits, then keep the working width
  assign wide  = {{(64-IN_BITS){value[IN_BITS-1]}}, value};
  assign raw   = wide[VALUE_BITS-1:0];
  assign mag   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !char_valid || char_ready;
  assign top        = mode_bin ? {3'b000, work[W-1]} : work[W-1 -: 4];

  i2a_dabble #(.VALUE_BITS(VALUE_BITS)) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (cmd == CMD_DEC)),
    .bin   (mag),
    .done  (dd_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
      mode_bin   <= 1'b0;
      rem        <= '0;
    end else begin
      if (char_valid && char_ready) char_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_DEC: begin
                mode_bin <= 1'b0;
                state    <= S_DABBLE;
              end
              CMD_BIN: begin
                mode_bin <= 1'b1;
                work     <= W'(mag) << (W - VALUE_BITS);
                rem      <= CW'(VALUE_BITS);
                state    <= S_SKIP;
              end
              CMD_HEX: begin
                mode_bin <= 1'b0;
                work     <= W'(raw) << (W - 4*H);
                rem      <= CW'(H);
                state    <= S_PFX0;
              end
              default: state <= S_IDLE;   // unused radix: item dropped
            endcase
          end
        end
        S_DABBLE: begin
          if (dd_done) begin
            work  <= W'(bcd) << (W - 4*D);
            rem   <= CW'(D);
            state <= S_SKIP;
          end
        end
        S_PFX0: begin
          if (out_free) begin
            character  <= CHAR_ZERO;
            last       <= 1'b0;
            char_valid <= 1'b1;
            state      <= S_PFX1;
          end
        end
        S_PFX1: begin
          if (out_free) begin
            character  <= CHAR_X;
            last       <= 1'b0;
            char_valid <= 1'b1;
            state      <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, always keep the final digit
          if (rem > CW'(1) && top == 4'd0) begin
            work <= mode_bin ? (work << 1) : (work << 4);
            rem  <= rem - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            character  <= digit_ascii(top);
            last       <= (rem == CW'(1));
            char_valid <= 1'b1;
            work       <= mode_bin ? (work << 1) : (work << 4);
            rem        <= rem - 1'b1;
            if (rem == CW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/integer_to_ascii_digits_core_tb.sv
// Testbench for integer_to_ascii_digits_core: directed table then random items, checked per character.
`timescale 1ns / 1ps

module integer_to_ascii_digits_core_tb;
  import i2a_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int HEX_NIBBLES = (VB + 3) / 4;

  // radix code the block must ignore
  localparam logic [1:0] CMD_NONE = 2'd3;

  // length of the one long receiver hold-off, in cycles
  localparam int SINK_HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
  } text_char_t;

  // one row of the directed table; text is only used where typed is set
  typedef struct {
    logic [1:0]         op;
    logic [IN_BITS-1:0] v;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [1:0]         cmd = CMD_DEC;
  logic [IN_BITS-1:0] value = '0;
  logic               char_valid;
  logic               char_ready = 1'b0;
  logic [7:0]         character;
  logic               last;

  text_char_t expected_text[$];
  int unsigned fails = 0;

  // idling switches and the hold-off request shared with the receiver process
  bit source_idles = 1'b1;
  bit sink_idles = 1'b1;
  bit sink_hold_req = 1'b0;
  int sink_hold_left = 0;

  // Directed items: extremes of each radix, zero, the most negative value, the unused
  // radix code. Rows with typed text carry an answer that can be read straight off;
  // the rest go through the predictor.
  stim_row_t directed_rows [25] = '{
    '{CMD_DEC,  32'h0000_0000, 1'b1, "0"},
    '{CMD_DEC,  32'h7fff_ffff, 1'b1, "2147483647"},
    '{CMD_DEC,  32'h8000_0000, 1'b1, "2147483648"},
    '{CMD_DEC,  32'hffff_ffff, 1'b1, "1"},
    '{CMD_DEC,  32'd9,         1'b0, ""},
    '{CMD_DEC,  32'd10,        1'b0, ""},
    '{CMD_DEC,  32'd1000000000, 1'b0, ""},
    '{CMD_DEC,  -32'sd123456789, 1'b0, ""},
    '{CMD_BIN,  32'h0000_0000, 1'b1, "0"},
    '{CMD_BIN,  32'h0000_0001, 1'b1, "1"},
    '{CMD_BIN,  32'h8000_0000, 1'b1, "10000000000000000000000000000000"},
    '{CMD_BIN,  32'hffff_ffff, 1'b1, "1"},
    '{CMD_BIN,  32'h7fff_ffff, 1'b0, ""},
    '{CMD_BIN,  32'h5555_5555, 1'b0, ""},
    '{CMD_BIN,  32'hffff_fffb, 1'b0, ""},
    '{CMD_HEX,  32'h0000_0000, 1'b1, "0x0"},
    '{CMD_HEX,  32'hffff_ffff, 1'b1, "0xffffffff"},
    '{CMD_HEX,  32'h8000_0000, 1'b1, "0x80000000"},
    '{CMD_HEX,  32'h7fff_ffff, 1'b1, "0x7fffffff"},
    '{CMD_HEX,  32'h0000_000a, 1'b1, "0xa"},
    '{CMD_HEX,  32'h00ab_cdef, 1'b0, ""},
    '{CMD_HEX,  32'h1234_5678, 1'b0, ""},
    '{CMD_HEX,  32'hffff_fff0, 1'b0, ""},
    '{CMD_NONE, 32'h0000_0000, 1'b1, ""},
    '{CMD_NONE, 32'hffff_ffff, 1'b1, ""}
  };

  integer_to_ascii_digits_core #(
    .VALUE_BITS(VB)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .cmd       (cmd),
    .value     (value),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .character (character),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected text for one item. Decimal and binary: digits of the magnitude, no sign.
  // Hex: "0x", then the raw pattern with leading zero nibbles dropped, "0x0" for zero.
  function automatic void predict_digits(input logic [1:0] op, input logic [IN_BITS-1:0] v);
    logic [VB-1:0]   raw;
    logic [VB-1:0]   mag;
    longint unsigned rest;
    longint unsigned radix;
    logic [3:0]      nib;
    bit              leading;
    logic [7:0]      digits[$];
    raw = v[VB-1:0];
    if (op == CMD_DEC || op == CMD_BIN) begin
      // negating the most negative value leaves it unchanged, which is the right magnitude
      mag = raw[VB-1] ? -raw : raw;
      rest = longint'(mag);
      radix = (op == CMD_DEC) ? 10 : 2;
      do begin
        digits.push_front(CHAR_ZERO + 8'(rest % radix));
        rest = rest / radix;
      end while (rest != 0);
    end else if (op == CMD_HEX) begin
      digits.push_back(CHAR_ZERO);
      digits.push_back(CHAR_X);
      leading = 1'b1;
      for (int i = HEX_NIBBLES - 1; i >= 0; i--) begin
        nib = 4'(raw >> (4 * i));
        if (!(nib == 4'd0 && leading)) begin
          leading = 1'b0;
          digits.push_back(nib < 4'd10 ? CHAR_ZERO + 8'(nib) : CHAR_A + 8'(nib) - 8'd10);
        end
      end
      if (leading) digits.push_back(CHAR_ZERO);
    end
    // unused radix code: nothing comes out
    foreach (digits[k]) expected_text.push_back('{ch: digits[k], lst: k == digits.size() - 1});
  endfunction

  function automatic void expect_typed(input string s);
    for (int k = 0; k < s.len(); k++) begin
      expected_text.push_back('{ch: s[k], lst: k == s.len() - 1});
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // valid is left high on return so that the next item can follow back to back.
  task automatic send_item(input logic [1:0] op, input logic [IN_BITS-1:0] v,
                           input bit typed, input string s);
    while (source_idles && $urandom_range(99) < 23) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd <= op;
    value <= v;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    // expectations land at the falling edge after acceptance: a character on the accepting
    // edge itself is then never matched against this item's text
    if (typed) expect_typed(s);
    else predict_digits(op, v);
  endtask

  // Mix of full-width, shortened, negated, single-bit and tiny values so that every
  // output length turns up in each radix.
  function automatic logic [IN_BITS-1:0] random_value();
    logic [IN_BITS-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: v = -($urandom >> $urandom_range(31));
      3: v = 32'd1 << $urandom_range(31);
      4: v = $urandom_range(15);
      default: v = -$urandom_range(16);
    endcase
    return v;
  endfunction

  // n counts converted items only; the unused radix code rides along for free
  task automatic send_random(input int n);
    int taken;
    logic [1:0] op;
    taken = 0;
    while (taken < n) begin
      op = ($urandom_range(99) < 5) ? CMD_NONE : 2'($urandom_range(2));
      send_item(op, random_value(), 1'b0, "");
      if (op != CMD_NONE) taken++;
    end
  endtask

  task automatic wait_text_drained();
    while (expected_text.size() != 0) @(negedge clk);
  endtask

  // Receiver: random ready, with the occasional long hold-off counted here
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_hold_left = SINK_HOLD_CYCLES;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        char_ready <= 1'b0;
      end else begin
        char_ready <= !(sink_idles && $urandom_range(99) < 23);
      end
    end
  end

  // Each character taken is held against the oldest expectation
  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (!rst && char_valid && char_ready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character: character %h, last %b", character, last);
        fails++;
      end else begin
        want = expected_text.pop_front();
        if (character !== want.ch) begin
          $error("mismatch on character: expected %h, actual %h", want.ch, character);
          fails++;
        end
        if (last !== want.lst) begin
          $error("mismatch on last: expected %b, actual %b", want.lst, last);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].v, directed_rows[i].typed,
                directed_rows[i].text);
    end

    // receiver goes quiet for a long while; the block fills and stalls its input
    send_random(40);
    sink_hold_req = 1'b1;
    send_random(80);

    // sender stops until all text is out
    item_valid <= 1'b0;
    wait_text_drained();

    // back to back on both sides
    source_idles = 1'b0;
    sink_idles = 1'b0;
    send_random(80);

    source_idles = 1'b1;
    sink_idles = 1'b1;
    send_random(100);

    item_valid <= 1'b0;
    wait_text_drained();
    // room for any stray character after the last expected one
    repeat (80) @(negedge clk);

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
